// ===== rtl/core/gcm_pkg.sv =====
package gcm_pkg;

   localparam int LEVEL_W    = 17;   // signed sample level
   localparam int STEP_LVL_W = 16;   // unsigned Q1.15 step level
   localparam int COMP_W     = 8;
   localparam int NUM_COMP   = 3;    // red, green, blue
   localparam int WORD_W     = 40;
   localparam int LVL_LSB    = 24;   // step level sits above the colour
   localparam int DIFF_W     = 16;
   localparam int NUM_W      = 24;   // interpolation numerator
   localparam int QUOT_W     = 8;    // quotient bits, one per divider stage
   localparam int CSR_IDX_W  = 3;
   localparam int TDATA_W    = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_WORD0 = 3'd1;

   localparam logic [2:0]        STEP_COUNT_RESET = 3'd2;
   localparam logic [WORD_W-1:0] STEP_WORD1_RESET = 40'h80_0000_0000;

   typedef logic [NUM_COMP-1:0][COMP_W-1:0] gcm_rgb_type;

   typedef struct packed {
      logic [NUM_COMP-1:0][NUM_W-1:0] num;
      logic [DIFF_W-1:0]              dvsr;
   } gcm_div_in_type;

endpackage

// ===== rtl/core/gradient_colormap_interp.sv =====
// Piecewise-linear colour map: one signed level sample in, one 8-bit RGB colour out.
// The request channel (req_) carries the level in req_tdata[16:0]; the response
// channel (rsp_) carries red, green and blue in rsp_tdata, red in the low byte.
// The gradient lives in csr_ registers: index 0 is the step count, indexes 1 and up
// are the packed step words. Write them only while no request is in flight.
// From request to response there are four front stages (input, segment search, segment
// select and differences, multiply), whose products are summed with the rounding term
// straight into an eight-stage divider that produces one quotient bit per stage.
// The last divider stage is the output register.
// Throughput is one request per cycle while rsp_tready is high. Every stage has its
// own valid bit and loads whenever it is empty or its content moves on, so bubbles
// close up and a new request is taken while a finished response still waits.
// When rsp_tready is low the output holds; the stages behind it fill up and
// req_tready drops only when all of them are full. Nothing is lost or repeated.
// Reset empties the pipeline and loads the default palette: two black steps at
// levels 0 and 1.0, step count 2.
module gradient_colormap_interp #(
   parameter int MAX_STEPS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gcm_pkg::TDATA_W-1:0]         req_tdata,   // level [16:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gcm_pkg::TDATA_W-1:0]         rsp_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                                csr_wr_en,
   input  logic [gcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gcm_pkg::WORD_W-1:0]          csr_wdata
);
   import gcm_pkg::*;

   localparam int STEP_IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   // configuration registers
   logic [2:0]        sc_ff;
   logic [WORD_W-1:0] word_ff [MAX_STEPS];

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   logic div_ready;

   // stage 1: input
   logic signed [LEVEL_W-1:0] x_ff;

   // stage 2: segment found
   logic                  interp_in, interp_ff;
   logic [STEP_IDX_W-1:0] idx_in, idx_ff;
   logic [14:0]           x15_ff;

   // stage 3: segment endpoints and differences
   gcm_rgb_type       c0_in, c1_in, c0_ff, c1_ff;
   logic [DIFF_W-1:0] bx_in, xa_in, dv3_in;
   logic [DIFF_W-1:0] bx_ff, xa_ff, dv3_ff;

   // stage 4: products
   logic [NUM_COMP-1:0][NUM_W-1:0] p0_in, p1_in, p0_ff, p1_ff;
   logic [DIFF_W-1:0]              dv4_ff;

   gcm_div_in_type div_in;
   gcm_rgb_type    div_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= STEP_COUNT_RESET;
         for (int k = 0; k < MAX_STEPS; k++) begin
            word_ff[k] <= (k == 1) ? STEP_WORD1_RESET : '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == CSR_STEP_COUNT) begin
            sc_ff <= csr_wdata[2:0];
         end
         for (int k = 0; k < MAX_STEPS; k++) begin
            if (csr_index == CSR_STEP_WORD0 + CSR_IDX_W'(k)) begin
               word_ff[k] <= csr_wdata;
            end
         end
      end
   end

   assign en4        = !v4_ff || div_ready;
   assign en3        = !v3_ff || en4;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // segment search: first step in use whose level is at least the sample
   always_comb begin
      logic [2:0]            n_eff;
      logic [STEP_IDX_W-1:0] last_idx;
      logic [STEP_IDX_W-1:0] kf;
      logic                  found;
      logic                  x_le0;
      logic                  x_ge1;
      if (sc_ff < 3'd2) begin
         n_eff = 3'd2;
      end else if (sc_ff > 3'(MAX_STEPS)) begin
         n_eff = 3'(MAX_STEPS);
      end else begin
         n_eff = sc_ff;
      end
      last_idx = STEP_IDX_W'(n_eff - 3'd1);
      x_le0    = x_ff[LEVEL_W-1] || (x_ff == '0);
      x_ge1    = !x_ff[LEVEL_W-1] && x_ff[15];
      kf       = '0;
      found    = 1'b0;
      for (int k = MAX_STEPS - 1; k >= 0; k--) begin
         if ((3'(k) < n_eff) &&
             ({1'b0, x_ff[14:0]} <= word_ff[k][LVL_LSB +: STEP_LVL_W])) begin
            kf    = STEP_IDX_W'(k);
            found = 1'b1;
         end
      end
      interp_in = 1'b0;
      idx_in    = '0;
      if (x_le0) begin
         idx_in = '0;
      end else if (x_ge1 || !found) begin
         idx_in = last_idx;
      end else if (kf != '0) begin
         interp_in = 1'b1;
         idx_in    = kf;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         interp_ff <= interp_in;
         idx_ff    <= idx_in;
         x15_ff    <= x_ff[14:0];
      end
      if (en1) begin
         x_ff <= req_tdata[LEVEL_W-1:0];
      end
   end

   // endpoints; a flat colour goes through as c1 * 1 / 1
   always_comb begin
      logic [WORD_W-1:0]     w0;
      logic [WORD_W-1:0]     w1;
      logic [STEP_LVL_W-1:0] lvl_a;
      logic [STEP_LVL_W-1:0] lvl_b;
      w0 = '0;
      w1 = '0;
      for (int k = 0; k < MAX_STEPS; k++) begin
         if (idx_ff == STEP_IDX_W'(k)) w1 = word_ff[k];
         if ((k + 1 < MAX_STEPS) && (idx_ff == STEP_IDX_W'(k + 1))) w0 = word_ff[k];
      end
      lvl_a = w0[LVL_LSB +: STEP_LVL_W];
      lvl_b = w1[LVL_LSB +: STEP_LVL_W];
      for (int j = 0; j < NUM_COMP; j++) begin
         c0_in[j] = w0[(NUM_COMP - 1 - j) * COMP_W +: COMP_W];
         c1_in[j] = w1[(NUM_COMP - 1 - j) * COMP_W +: COMP_W];
      end
      if (interp_ff) begin
         bx_in  = lvl_b - {1'b0, x15_ff};
         xa_in  = {1'b0, x15_ff} - lvl_a;
         dv3_in = lvl_b - lvl_a;
      end else begin
         bx_in  = '0;
         xa_in  = DIFF_W'(1);
         dv3_in = DIFF_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         c0_ff  <= c0_in;
         c1_ff  <= c1_in;
         bx_ff  <= bx_in;
         xa_ff  <= xa_in;
         dv3_ff <= dv3_in;
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_COMP; j++) begin
         p0_in[j] = NUM_W'(c0_ff[j]) * NUM_W'(bx_ff);
         p1_in[j] = NUM_W'(c1_ff[j]) * NUM_W'(xa_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         dv4_ff <= dv3_ff;
      end
   end

   // numerator with half the divisor added for round to nearest
   always_comb begin
      for (int j = 0; j < NUM_COMP; j++) begin
         div_in.num[j] = p0_ff[j] + p1_ff[j] + NUM_W'(dv4_ff >> 1);
      end
      div_in.dvsr = dv4_ff;
   end

   gcm_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (div_ready),
      .in_data   (div_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_quot  (div_quot)
   );

   assign rsp_tdata = div_quot;

   a_interp_has_lower_step : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && interp_ff) |-> (idx_ff != '0))
      else $error("interpolation selected with no lower step");

   a_segment_split : assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((dv3_ff != '0) && (DIFF_W'(bx_ff + xa_ff) == dv3_ff)))
      else $error("segment width does not match its two parts");

   a_quotient_fits : assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> ((32'(div_in.num[0]) < {dv4_ff, 8'b0}) &&
                 (32'(div_in.num[1]) < {dv4_ff, 8'b0}) &&
                 (32'(div_in.num[2]) < {dv4_ff, 8'b0})))
      else $error("numerator gives a quotient above one byte");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("request refused while a front stage is empty");

endmodule

// ===== rtl/core/gcm_div_pipe.sv =====
module gcm_div_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gcm_pkg::gcm_div_in_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gcm_pkg::gcm_rgb_type    out_quot
);
   import gcm_pkg::*;

   logic [QUOT_W-1:0] v_ff;
   logic [QUOT_W-1:0] en;

   logic [NUM_COMP-1:0][NUM_W-1:0]  rem_ff   [QUOT_W];
   logic [NUM_COMP-1:0][NUM_W-1:0]  rem_in   [QUOT_W];
   logic [NUM_COMP-1:0][QUOT_W-1:0] quot_ff  [QUOT_W];
   logic [NUM_COMP-1:0][QUOT_W-1:0] quot_in  [QUOT_W];
   logic [DIFF_W-1:0]               dvsr_ff  [QUOT_W];
   logic [DIFF_W-1:0]               dvsr_in  [QUOT_W];

   // a stage may load when it is empty or its content moves on
   always_comb begin
      en[QUOT_W-1] = !v_ff[QUOT_W-1] || out_ready;
      for (int i = QUOT_W - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   // restoring division, one quotient bit per stage, msb first
   always_comb begin
      logic [NUM_W-1:0]  r_src;
      logic [NUM_W-1:0]  dsh;
      logic [QUOT_W-1:0] q_src;
      for (int i = 0; i < QUOT_W; i++) begin
         dvsr_in[i] = (i == 0) ? in_data.dvsr : dvsr_ff[i-1];
         for (int j = 0; j < NUM_COMP; j++) begin
            if (i == 0) begin
               r_src = in_data.num[j];
               q_src = '0;
            end else begin
               r_src = rem_ff[i-1][j];
               q_src = quot_ff[i-1][j];
            end
            dsh = NUM_W'(dvsr_in[i]) << (QUOT_W - 1 - i);
            if (r_src >= dsh) begin
               rem_in[i][j]  = r_src - dsh;
               quot_in[i][j] = q_src | (QUOT_W'(1) << (QUOT_W - 1 - i));
            end else begin
               rem_in[i][j]  = r_src;
               quot_in[i][j] = q_src;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < QUOT_W; i++) begin
            if (en[i]) begin
               v_ff[i] <= (i == 0) ? in_valid : v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUOT_W; i++) begin
         if (en[i]) begin
            rem_ff[i]  <= rem_in[i];
            quot_ff[i] <= quot_in[i];
            dvsr_ff[i] <= dvsr_in[i];
         end
      end
   end

   assign out_valid = v_ff[QUOT_W-1];

   always_comb begin
      for (int j = 0; j < NUM_COMP; j++) begin
         out_quot[j] = quot_ff[QUOT_W-1][j];
      end
   end

endmodule

// ===== tb/colormap_checker.sv =====
`timescale 1ns / 100ps

module colormap_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [gcm_pkg::TDATA_W-1:0]   req_tdata,   // level [16:0]
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [gcm_pkg::TDATA_W-1:0]   rsp_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                          csr_wr_en,
   input  logic [gcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcm_pkg::WORD_W-1:0]    csr_wdata,
   output int                            error_count,
   output int                            colours_pending
);
   import gcm_pkg::*;

   localparam int NUM_STEPS = 7;
   localparam int ONE_LEVEL = 32768;

   typedef struct packed {
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] red;
   } colour_type;

   typedef struct {
      logic [LEVEL_W-1:0] level;
      colour_type         colour;
   } pending_colour_type;

   logic [2:0]         gradient_count;
   logic [WORD_W-1:0]  gradient_words [NUM_STEPS];
   pending_colour_type expected_colours [$];
   pending_colour_type oldest;
   colour_type         seen;

   initial begin
      error_count     = 0;
      colours_pending = 0;
   end

   function automatic colour_type word_colour(input logic [WORD_W-1:0] w);
      colour_type c;
      c.red   = w[23:16];
      c.green = w[15:8];
      c.blue  = w[7:0];
      return c;
   endfunction

   function automatic logic [15:0] word_level(input logic [WORD_W-1:0] w);
      return w[WORD_W-1:LVL_LSB];
   endfunction

   // linear blend across one segment, half rounds up
   function automatic logic [COMP_W-1:0] blend(input logic [COMP_W-1:0] c0,
                                               input logic [COMP_W-1:0] c1,
                                               input longint lo, input longint hi,
                                               input longint x);
      longint width;
      longint num;
      width = hi - lo;
      num   = longint'(c0) * (hi - x) + longint'(c1) * (x - lo) + width / 2;
      return COMP_W'(num / width);
   endfunction

   function automatic colour_type map_level_to_colour(input logic [LEVEL_W-1:0] sample);
      int         active;
      int         k;
      longint     x;
      longint     lo;
      longint     hi;
      colour_type c0;
      colour_type c1;
      colour_type result;
      active = (gradient_count < 2) ? 2 : int'(gradient_count);
      x = longint'($signed(sample));
      if (x <= 0)
         return word_colour(gradient_words[0]);
      if (x >= ONE_LEVEL)
         return word_colour(gradient_words[active-1]);
      k = 0;
      while (k < active && x > longint'(word_level(gradient_words[k])))
         k++;
      if (k == 0)
         return word_colour(gradient_words[0]);
      if (k >= active)
         return word_colour(gradient_words[active-1]);
      // first step at or above the sample closes the segment
      lo = longint'(word_level(gradient_words[k-1]));
      hi = longint'(word_level(gradient_words[k]));
      c0 = word_colour(gradient_words[k-1]);
      c1 = word_colour(gradient_words[k]);
      result.red   = blend(c0.red,   c1.red,   lo, hi, x);
      result.green = blend(c0.green, c1.green, lo, hi, x);
      result.blue  = blend(c0.blue,  c1.blue,  lo, hi, x);
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("error at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_component(input string name, input logic [16:0] level,
                                  input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("level %0d %s got %0d expected %0d",
                                   $signed(level), name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gradient_count = STEP_COUNT_RESET;
         foreach (gradient_words[i])
            gradient_words[i] = '0;
         gradient_words[1] = STEP_WORD1_RESET;
         expected_colours.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_STEP_COUNT)
               gradient_count = csr_wdata[2:0];
            else
               gradient_words[csr_index - CSR_STEP_WORD0] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = colour_type'(rsp_tdata);
            if (expected_colours.size() == 0) begin
               report_mismatch($sformatf("unexpected colour %06h", rsp_tdata));
            end else begin
               oldest = expected_colours.pop_front();
               check_component("red",   oldest.level, seen.red,   oldest.colour.red);
               check_component("green", oldest.level, seen.green, oldest.colour.green);
               check_component("blue",  oldest.level, seen.blue,  oldest.colour.blue);
            end
         end
         if (req_tvalid && req_tready) begin
            oldest.level  = req_tdata[LEVEL_W-1:0];
            oldest.colour = map_level_to_colour(req_tdata[LEVEL_W-1:0]);
            expected_colours.push_back(oldest);
         end
      end
      colours_pending <= expected_colours.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import gcm_pkg::*;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int PALETTES_PER_PASS = 4;
   localparam int LEVELS_PER_PALETTE = 160;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_wdata  = '0;

   int error_count;
   int colours_pending;
   int cycle_count = 0;
   int send_idle_pct = 15;
   int rsp_idle_pct = 70;

   // step levels currently loaded, used to aim samples at segment edges
   logic [15:0] step_levels [7];

   gradient_colormap_interp DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   colormap_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .colours_pending (colours_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // called at a rising edge, returns at a rising edge with the pipeline empty
   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (colours_pending != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_level(input logic [LEVEL_W-1:0] sample);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(TDATA_W-LEVEL_W){1'b0}}, sample};
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_palette(input logic [2:0] count, input logic [WORD_W-1:0] words [7]);
      wait_drained(16);
      write_reg(CSR_STEP_COUNT, WORD_W'(count));
      for (int i = 0; i < 7; i++) begin
         write_reg(CSR_STEP_WORD0 + CSR_IDX_W'(i), words[i]);
         step_levels[i] = words[i][WORD_W-1:LVL_LSB];
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] random_component();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0)
         return 8'h00;
      if (pick == 1)
         return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   task automatic random_palette();
      logic [WORD_W-1:0] words [7];
      logic [2:0]        count;
      int                lvl;
      int                style;
      style = $urandom_range(9);
      count = 3'($urandom_range(7));
      lvl   = $urandom_range(2000);
      for (int i = 0; i < 7; i++) begin
         if (style == 0) begin
            // arbitrary words: unsorted levels, levels past 1.0
            words[i] = WORD_W'({$urandom, $urandom});
         end else begin
            lvl += (style == 1) ? $urandom_range(1, 3) : $urandom_range(1, 9000);
            words[i] = {lvl[15:0], random_component(), random_component(), random_component()};
         end
      end
      load_palette(count, words);
   endtask

   function automatic logic [LEVEL_W-1:0] pick_level();
      int sel;
      int base;
      sel = $urandom_range(99);
      if (sel < 45)
         return LEVEL_W'($urandom_range(1, 32767));
      if (sel < 75) begin
         base = int'(step_levels[$urandom_range(6)]);
         return LEVEL_W'(base + $urandom_range(4) - 2);
      end
      if (sel < 90)
         return LEVEL_W'($urandom);
      case ($urandom_range(6))
         0: return LEVEL_W'(-65536);
         1: return LEVEL_W'(-1);
         2: return LEVEL_W'(0);
         3: return LEVEL_W'(1);
         4: return LEVEL_W'(32767);
         5: return LEVEL_W'(32768);
         default: return LEVEL_W'(65535);
      endcase
   endfunction

   task automatic random_pass(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = recv_pct;
      for (int p = 0; p < PALETTES_PER_PASS; p++) begin
         random_palette();
         for (int n = 0; n < LEVELS_PER_PALETTE; n++)
            send_level(pick_level());
      end
   endtask

   initial begin
      logic [WORD_W-1:0] words [7];
      step_levels = '{default: '0};
      step_levels[1] = 16'h8000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default palette is black everywhere
      send_level(LEVEL_W'(-65536));
      send_level(LEVEL_W'(0));
      send_level(LEVEL_W'(16384));
      send_level(LEVEL_W'(65535));

      // seven steps: width-one and width-two segments, ends at 0 and 1.0
      words[0] = {16'd0,     24'h000000};
      words[1] = {16'd1,     24'hFFFFFF};
      words[2] = {16'd5000,  24'h1280FF};
      words[3] = {16'd5002,  24'h0001FE};
      words[4] = {16'd16384, 24'hFF007F};
      words[5] = {16'd32767, 24'h40C001};
      words[6] = {16'd32768, 24'hABCDEF};
      load_palette(3'd7, words);
      send_level(LEVEL_W'(-1));
      send_level(LEVEL_W'(1));
      send_level(LEVEL_W'(2));
      send_level(LEVEL_W'(5001));
      send_level(LEVEL_W'(5002));
      send_level(LEVEL_W'(10693));
      send_level(LEVEL_W'(32766));
      send_level(LEVEL_W'(32767));
      send_level(LEVEL_W'(32768));

      // count below two acts as two; step 0 above zero; all-ones words unused
      words[0] = {16'd100,   24'h0A141E};
      words[1] = {16'hFFFF,  24'hFFFFFF};
      for (int i = 2; i < 7; i++)
         words[i] = '1;
      load_palette(3'd0, words);
      send_level(LEVEL_W'(50));
      send_level(LEVEL_W'(100));
      send_level(LEVEL_W'(101));
      send_level(LEVEL_W'(32767));
      send_level(LEVEL_W'(32768));

      // sample above the last step in use
      words[0] = {16'd10, 24'h102030};
      words[1] = {16'd20, 24'h405060};
      words[2] = {16'd30, 24'hC0D0E0};
      load_palette(3'd3, words);
      send_level(LEVEL_W'(25));
      send_level(LEVEL_W'(31));

      // unsorted steps: search takes the first step at or above the sample
      words[0] = {16'd100, 24'h00FF00};
      words[1] = {16'd50,  24'hFF0000};
      words[2] = {16'd300, 24'h0000FF};
      words[3] = {16'd200, 24'h808080};
      load_palette(3'd4, words);
      send_level(LEVEL_W'(60));
      send_level(LEVEL_W'(150));
      send_level(LEVEL_W'(250));

      random_pass(15, 70);
      random_pass(70, 15);
      random_pass(0, 0);

      wait_drained(30);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
